// File: hdl/tot_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Shared types, codes and constants of the one-shot timer table.
// ----------------------------------------------------------------------------
package tot_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

   localparam int KIND_W     = 2;
   localparam int EVENT_W    = 3;
   localparam int SLOT_IO_W  = 4;
   localparam int TICK_W     = 64;
   localparam int TAG_W      = 32;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 168;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_CREATE = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_CREATED   = 3'd0,
      EV_FULL      = 3'd1,
      EV_CANCELLED = 3'd2,
      EV_EXPIRED   = 3'd3,
      EV_IDLE_TICK = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_START,
      ST_SCAN_EVAL,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_PEND_MID,
      RSP_PEND_LAST,
      RSP_IDLE_TICK,
      RSP_CREATE,
      RSP_CANCEL
   } rsp_sel_type;

   // One slot of the timer table as it sits in the slot memory.
   typedef struct packed {
      logic [TICK_W-1:0] id;
      logic [TICK_W-1:0] start;
      logic [TICK_W-1:0] timeout;
      logic [TAG_W-1:0]  tag;
   } slot_rec_type;

   typedef struct packed {
      logic        capture;
      logic        read_first;
      logic        advance;
      logic        take;
      rsp_sel_type rsp_sel;
   } ctl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
      logic     due;
      logic     pend_valid;
      logic     scan_end;
      logic     cap_next;
   } ctl_stat_type;

endpackage

// File: hdl/tot_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tot_ctrl.sv
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences create, cancel and tick scans and drives the datapath commands.
// ----------------------------------------------------------------------------
module tot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  tot_pkg::kind_type     req_kind,
   output logic                  req_tready,
   input  tot_pkg::ctl_stat_type stat,
   output tot_pkg::ctl_cmd_type  cmd
);

   import tot_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.rsp_sel = RSP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_kind == KIND_TICK) ? ST_SCAN_START : ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (stat.kind)
               KIND_CREATE: begin
                  if (stat.out_free) begin
                     cmd.rsp_sel = RSP_CREATE;
                     state_in    = ST_IDLE;
                  end
               end
               KIND_CANCEL: begin
                  if (stat.out_free) begin
                     cmd.rsp_sel = RSP_CANCEL;
                     state_in    = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN_START: begin
            cmd.read_first = 1'b1;
            state_in       = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            if (stat.due) begin
               // A held expiry must leave before the next one takes its place.
               if (!stat.pend_valid || stat.out_free) begin
                  cmd.take    = 1'b1;
                  cmd.rsp_sel = stat.pend_valid ? RSP_PEND_MID : RSP_NONE;
                  if (stat.scan_end || stat.cap_next) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
            end else if (stat.scan_end) begin
               state_in = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_sel = stat.pend_valid ? RSP_PEND_LAST : RSP_IDLE_TICK;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/tot_datapath.sv
// ----------------------------------------------------------------------------
// Timer table datapath
// Tick counter, id counter, active flags, slot memory, scan and result register.
// ----------------------------------------------------------------------------
module tot_datapath #(
   parameter int NUM_SLOTS = tot_pkg::NUM_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tot_pkg::KIND_W-1:0]       req_tuser,
   input  logic [tot_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  tot_pkg::ctl_cmd_type             cmd,
   output tot_pkg::ctl_stat_type            stat,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tot_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [tot_pkg::EVENT_W-1:0]      rsp_tuser,
   output logic                             rsp_tlast
);

   import tot_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int REC_W  = $bits(slot_rec_type);

   // Captured item.
   kind_type             kind_ff;
   logic [TICK_W-1:0]    timeout_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [SLOT_IO_W-1:0] slot_in_ff;

   // Table state.
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [TICK_W-1:0]    next_id_ff, next_id_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;

   // Scan state.
   logic [SLOT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pend_valid_ff, pend_valid_in;
   slot_rec_type         pend_rec_ff;
   logic [SLOT_W-1:0]    pend_slot_ff;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   event_type            rsp_event_ff, rsp_event_in;
   logic [SLOT_IO_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TICK_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [TICK_W-1:0]    rsp_tick_ff;
   logic                 rsp_last_ff, rsp_last_in;

   logic [SLOT_W-1:0]    free_idx;
   logic                 any_free;
   logic                 out_free;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [SLOT_W-1:0]    ram_rd_addr;
   slot_rec_type         wr_rec;
   slot_rec_type         rd_rec;
   logic [REC_W-1:0]     rd_bits;
   logic [TICK_W-1:0]    elapsed;
   logic [SLOT_W+SLOT_IO_W-1:0] pend_slot_ext;
   logic [SLOT_W+SLOT_IO_W-1:0] free_slot_ext;

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign any_free  = ~&active_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign ram_wr_en = (cmd.rsp_sel == RSP_CREATE) && any_free;
   assign ram_rd_en = cmd.read_first || cmd.advance;
   assign ram_rd_addr = cmd.advance ? scan_idx_ff + 1'b1 : scan_idx_ff;

   assign wr_rec.id      = next_id_ff;
   assign wr_rec.start   = tick_ff;
   assign wr_rec.timeout = timeout_ff;
   assign wr_rec.tag     = tag_ff;

   tot_ram #(
      .WIDTH (REC_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx),
      .wr_data (wr_rec),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_rec  = rd_bits;
   assign elapsed = tick_ff - rd_rec.start;

   assign stat.kind       = kind_ff;
   assign stat.out_free   = out_free;
   assign stat.due        = active_ff[scan_idx_ff] && (elapsed >= rd_rec.timeout);
   assign stat.pend_valid = pend_valid_ff;
   assign stat.scan_end   = scan_idx_ff == SLOT_W'(NUM_SLOTS - 1);
   assign stat.cap_next   = cnt_ff == CNT_W'(MAX_RESULTS - 1);

   // Slot indexes leave as their low four bits.
   assign pend_slot_ext = {{SLOT_IO_W{1'b0}}, pend_slot_ff};
   assign free_slot_ext = {{SLOT_IO_W{1'b0}}, free_idx};

   always_comb begin
      tick_in       = tick_ff;
      next_id_in    = next_id_ff;
      active_in     = active_ff;
      scan_idx_in   = scan_idx_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;

      if (cmd.capture) begin
         scan_idx_in   = '0;
         cnt_in        = '0;
         pend_valid_in = 1'b0;
         if (req_tuser == KIND_TICK) begin
            tick_in = tick_ff + 1'b1;
         end
      end
      if (cmd.advance) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (cmd.take) begin
         cnt_in        = cnt_ff + 1'b1;
         pend_valid_in = 1'b1;
      end
      if (ram_wr_en) begin
         next_id_in = next_id_ff + 1'b1;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (cmd.take && scan_idx_ff == SLOT_W'(i)) begin
            active_in[i] = 1'b0;
         end
         if (cmd.rsp_sel == RSP_CANCEL && {3'b000, slot_in_ff} == 7'(i)) begin
            active_in[i] = 1'b0;
         end
         if (ram_wr_en && free_idx == SLOT_W'(i)) begin
            active_in[i] = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_event_in = rsp_event_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.rsp_sel != RSP_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = '0;
         rsp_id_in    = '0;
         rsp_tag_in   = '0;
         rsp_last_in  = 1'b1;
      end
      case (cmd.rsp_sel)
         RSP_PEND_MID, RSP_PEND_LAST: begin
            rsp_event_in = EV_EXPIRED;
            rsp_slot_in  = pend_slot_ext[SLOT_IO_W-1:0];
            rsp_id_in    = pend_rec_ff.id;
            rsp_tag_in   = pend_rec_ff.tag;
            rsp_last_in  = cmd.rsp_sel == RSP_PEND_LAST;
         end
         RSP_IDLE_TICK: begin
            rsp_event_in = EV_IDLE_TICK;
         end
         RSP_CREATE: begin
            if (any_free) begin
               rsp_event_in = EV_CREATED;
               rsp_slot_in  = free_slot_ext[SLOT_IO_W-1:0];
               rsp_id_in    = next_id_ff;
            end else begin
               rsp_event_in = EV_FULL;
            end
         end
         RSP_CANCEL: begin
            rsp_event_in = EV_CANCELLED;
            rsp_slot_in  = slot_in_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         next_id_ff    <= TICK_W'(1);
         active_ff     <= '0;
         scan_idx_ff   <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_ff       <= tick_in;
         next_id_ff    <= next_id_in;
         active_ff     <= active_in;
         scan_idx_ff   <= scan_idx_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= kind_type'(req_tuser);
         timeout_ff <= req_tdata[63:0];
         tag_ff     <= req_tdata[95:64];
         slot_in_ff <= req_tdata[99:96];
      end
      if (cmd.take) begin
         pend_rec_ff  <= rd_rec;
         pend_slot_ff <= scan_idx_ff;
      end
      if (cmd.rsp_sel != RSP_NONE) begin
         rsp_tick_ff <= tick_ff;
      end
      rsp_event_ff <= rsp_event_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_tick_ff, rsp_tag_ff, rsp_id_ff, rsp_slot_ff};

endmodule

// File: hdl/one_shot_timer_table.sv
// ----------------------------------------------------------------------------
// One-shot timer table
// A table of one-shot timers with a 64-bit tick counter that counts tick items.
// ----------------------------------------------------------------------------
// Results: a create or cancel result is registered from the execute state
//   after its item is accepted; a tick's final result follows its scan.
// Flow: a new item is taken only in the idle state, so the block is through
//   with one item before it takes the next; the tick scan reads one slot a
//   cycle through the single read port of the slot memory, unless a held
//   expiry waits on a stalled result side.
// Reset: tick counter to 0, next id to 1, every slot inactive; the slot
//   memory is not cleared, as slot data counts only while the slot is active.
// ----------------------------------------------------------------------------
module one_shot_timer_table #(
   parameter int NUM_SLOTS = tot_pkg::NUM_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   // Request items.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata fields from bit 0 up: timeout [63:0], tag_in [95:64],
   // slot_in [99:96], zero fill [103:100].
   input  logic [tot_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser fields: kind [1:0] (0 tick, 1 create, 2 cancel).
   input  logic [tot_pkg::KIND_W-1:0]     req_tuser,

   // Result items.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata fields from bit 0 up: slot_out [3:0], timer_id [67:4],
   // tag_out [99:68], tick_now [163:100], zero fill [167:164].
   output logic [tot_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser fields: event_res [2:0].
   output logic [tot_pkg::EVENT_W-1:0]    rsp_tuser,
   // Marks the final result item of one request item.
   output logic                           rsp_tlast
);

   import tot_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // The controller walks each item through its steps: a create or cancel
   // passes the execute state; a tick starts the slot scan and checks one
   // slot per cycle unless a held expiry waits, holding the latest expiry
   // back until it knows whether another follows so the last can be marked.
   tot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (kind_type'(req_tuser)),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the counters, the active flags, the slot memory and
   // the result register that lets a new item in while a result waits.
   tot_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A new result is only loaded when the result register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_sel != RSP_NONE |-> stat.out_free)
      else $error("result register overwritten");

   // Taking a new expiry while one is held must push the held one out.
   assert property (@(posedge clock) disable iff (reset)
      cmd.take && stat.pend_valid |-> cmd.rsp_sel == RSP_PEND_MID)
      else $error("held expiry lost");

   // In the cycle after an item is accepted the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

endmodule
